### rtl/cpts_pkg.sv
`timescale 1ns / 1ps
package cpts_pkg;
    localparam int SLOTS = 16;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        CMD_TICK = 4'd0, CMD_ADD = 4'd1, CMD_DEL = 4'd2, CMD_DELALL = 4'd3,
        CMD_PAUSE = 4'd4, CMD_RESUME = 4'd5, CMD_SETD = 4'd6, CMD_GETD = 4'd7,
        CMD_START = 4'd8, CMD_STOP = 4'd9
    } cmd_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] KIND_PERIODIC = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_OVERRIDE = 2'd2;

    // frame record: id, len, bytes, period, kind, remaining = 131 bits
    typedef struct packed {
        logic [28:0] ident;
        logic [3:0]  len;
        logic [63:0] bytes;
        logic [15:0] period;
        logic [1:0]  kind;
        logic [15:0] remaining;
    } rec_t;

    localparam int RECW = $bits(rec_t);

    typedef struct packed {
        rec_t        rec;
        logic [31:0] sent_at;
    } slot_t;

    localparam int SLOTW = $bits(slot_t);

    function automatic logic [63:0] len_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
            if (len > 4'(b)) m[b*8 +: 8] = 8'hFF;
        return m;
    endfunction
endpackage

### rtl/cpts_ram.sv
`timescale 1ns / 1ps
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### rtl/can_periodic_tx_scheduler.sv
`timescale 1ns / 1ps
// A request walks the slot memory with a read and a check per slot; an add with no
// matching id walks it again to find a free slot. Stop and unknown commands go
// straight to the result, and a tick while stopped is taken with no result. A tick
// spends an emit step per due frame, plus an override backup scan, and waits on
// out_ready; one request at a time.
// Reset clears valid, backup-present, clock and run flag, then zeroes the slot memory
// before the first request.
module can_periodic_tx_scheduler
    import cpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cmd,
    input  logic [28:0] msg_id,
    input  logic [3:0]  dlc,
    input  logic [63:0] payload,
    input  logic [15:0] period_ms,
    input  logic [1:0]  send_type,
    input  logic [15:0] repeat_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        is_frame,
    output logic [28:0] out_id,
    output logic [3:0]  out_dlc,
    output logic [63:0] out_data,
    output logic        last
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_CHK, S_ADD2RD, S_ADD2CHK, S_BRD, S_BCHK, S_EMIT, S_FIN
    } state_t;

    state_t state_reg;
    logic [SLOTS-1:0] valid_reg, bpres_reg;
    logic [31:0] clock_reg;
    logic running_reg;
    logic [3:0] cmd_reg;
    logic [28:0] id_reg;
    logic [3:0] dlc_reg;
    logic [63:0] pay_reg;
    logic [15:0] per_reg, cnt_reg;
    logic [1:0] kind_reg;
    logic [CW-1:0] idx_reg, bidx_reg;
    logic hit_reg, emitted_reg;
    logic [1:0] st_reg;
    logic [3:0] rlen_reg;
    logic [63:0] rdata_reg;
    slot_t cur_reg;

    // output register
    logic ov_reg, of_reg, ol_reg;
    logic [1:0] os_reg;
    logic [28:0] oid_reg;
    logic [3:0] odlc_reg;
    logic [63:0] odata_reg;

    logic s_we, b_we;
    logic [SW-1:0] s_waddr, s_raddr, b_waddr, b_raddr;
    slot_t s_wdata, s_rdata;
    rec_t b_wdata, b_rdata;

    cpts_ram #(.WIDTH(SLOTW), .DEPTH(SLOTS)) u_slot (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));
    cpts_ram #(.WIDTH(RECW), .DEPTH(SLOTS)) u_bkp (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata));

    logic [SW-1:0] idx;
    logic out_free;
    logic [3:0] dlc_sat;
    rec_t new_rec;
    logic sv;
    logic [31:0] age;
    logic due;
    slot_t tick_cur;
    logic restore;
    logic out_load, o_frame, o_last;
    logic [1:0] o_st;
    logic [28:0] o_id;
    logic [3:0] o_dlc;
    logic [63:0] o_data;

    assign idx = idx_reg[SW-1:0];
    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign dlc_sat = (dlc > 4'd8) ? 4'd8 : dlc;
    assign new_rec = '{ident: id_reg, len: dlc_reg, bytes: pay_reg, period: per_reg,
                       kind: kind_reg, remaining: cnt_reg};
    assign sv = valid_reg[idx];
    assign age = clock_reg - s_rdata.sent_at;
    assign due = sv && (age >= {16'd0, s_rdata.rec.period});
    assign restore = (s_rdata.rec.kind == KIND_OVERRIDE) &&
                     (s_rdata.rec.remaining == 16'd1);

    assign s_raddr = idx;
    assign b_raddr = bidx_reg[SW-1:0];

    // slot as written back after it is sent
    always_comb
    begin
        tick_cur = s_rdata;
        tick_cur.sent_at = clock_reg;
        if (s_rdata.rec.kind == KIND_EVENT)
        begin
            if (s_rdata.rec.remaining <= 16'd1)
                tick_cur.rec.remaining = '0;
            else
                tick_cur.rec.remaining = s_rdata.rec.remaining - 16'd1;
        end
        else if (s_rdata.rec.kind == KIND_OVERRIDE && s_rdata.rec.remaining != 16'd0)
            tick_cur.rec.remaining = s_rdata.rec.remaining - 16'd1;
    end

    // write-back of the slot under examination
    always_comb
    begin
        s_we = 1'b0;
        s_waddr = idx;
        s_wdata = s_rdata;
        b_we = 1'b0;
        b_waddr = idx;
        b_wdata = new_rec;
        if (state_reg == S_CLR)
        begin
            s_we = 1'b1;
            s_wdata = '0;
        end
        else if (state_reg == S_CHK)
        begin
            unique case (cmd_reg)
                CMD_ADD:
                    if (sv && s_rdata.rec.ident == id_reg && !hit_reg)
                    begin
                        s_we = 1'b1;
                        s_wdata.rec = new_rec;
                    end
                CMD_DEL:
                    if (s_rdata.rec.ident == id_reg && !hit_reg)
                    begin
                        s_we = 1'b1;
                        s_wdata = '0;
                    end
                CMD_DELALL:
                    if (sv)
                    begin
                        s_we = 1'b1;
                        s_wdata = '0;
                    end
                CMD_SETD:
                    if (sv && s_rdata.rec.ident == id_reg)
                    begin
                        s_we = 1'b1;
                        s_wdata.rec.bytes = (s_rdata.rec.bytes & ~len_mask(s_rdata.rec.len))
                                          | (pay_reg & len_mask(s_rdata.rec.len));
                    end
                CMD_START:
                    if (sv)
                    begin
                        s_we = 1'b1;
                        s_wdata.sent_at = '0;
                    end
                default: ;
            endcase
        end
        else if (state_reg == S_ADD2CHK && !sv && !hit_reg)
        begin
            s_we = 1'b1;
            s_wdata = '{rec: new_rec, sent_at: 32'd0};
            b_we = (kind_reg != KIND_EVENT);
        end
        else if (state_reg == S_EMIT)
        begin
            s_we = 1'b1;
            s_wdata = cur_reg;
        end
    end

    // a held frame goes out when the next one is found (last low) or at the end
    always_comb
    begin
        out_load = 1'b0;
        o_st = ST_OK;
        o_frame = 1'b1;
        o_last = 1'b0;
        o_id = id_reg;
        o_dlc = rlen_reg;
        o_data = rdata_reg;
        if (state_reg == S_CHK && cmd_reg == CMD_TICK && due && emitted_reg && out_free)
            out_load = 1'b1;
        else if (state_reg == S_FIN && out_free)
        begin
            o_last = 1'b1;
            if (cmd_reg == CMD_TICK)
                out_load = emitted_reg;
            else
            begin
                out_load = 1'b1;
                o_frame = 1'b0;
                o_id = '0;
                o_dlc = (cmd_reg == CMD_GETD) ? rlen_reg : 4'd0;
                o_data = (cmd_reg == CMD_GETD) ? rdata_reg : 64'd0;
                if (cmd_reg == CMD_ADD)
                    o_st = hit_reg ? ST_OK : ST_FULL;
                else if (cmd_reg == CMD_DEL || cmd_reg == CMD_PAUSE ||
                         cmd_reg == CMD_RESUME || cmd_reg == CMD_SETD ||
                         cmd_reg == CMD_GETD)
                    o_st = hit_reg ? ST_OK : ST_NOTFOUND;
                else
                    o_st = st_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            valid_reg <= '0;
            bpres_reg <= '0;
            clock_reg <= '0;
            running_reg <= 1'b0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            bidx_reg <= '0;
            hit_reg <= 1'b0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                ov_reg <= 1'b1;
                os_reg <= o_st;
                of_reg <= o_frame;
                ol_reg <= o_last;
                oid_reg <= o_id;
                odlc_reg <= o_dlc;
                odata_reg <= o_data;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                    if (idx_reg == CW'(SLOTS - 1))
                    begin
                        idx_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                S_IDLE:
                    if (in_valid)
                    begin
                        cmd_reg <= cmd;
                        id_reg <= msg_id;
                        dlc_reg <= dlc_sat;
                        pay_reg <= payload;
                        per_reg <= period_ms;
                        kind_reg <= send_type;
                        cnt_reg <= repeat_count;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        emitted_reg <= 1'b0;
                        st_reg <= ST_OK;
                        rlen_reg <= '0;
                        rdata_reg <= '0;
                        if (cmd == CMD_TICK)
                        begin
                            if (running_reg)
                            begin
                                clock_reg <= clock_reg + 32'd1;
                                state_reg <= S_RD;
                            end
                        end
                        else if (cmd == CMD_STOP)
                        begin
                            running_reg <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        else if (cmd == CMD_START)
                        begin
                            clock_reg <= '0;
                            running_reg <= 1'b1;
                            state_reg <= S_RD;
                        end
                        else if (cmd > CMD_STOP)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_RD;
                    end
                S_RD:
                    state_reg <= S_CHK;
                S_CHK:
                    if (cmd_reg == CMD_TICK && due)
                    begin
                        // wait here while a held frame cannot be pushed out
                        if (!emitted_reg || out_free)
                        begin
                            cur_reg <= tick_cur;
                            id_reg <= s_rdata.rec.ident;
                            rlen_reg <= s_rdata.rec.len;
                            rdata_reg <= s_rdata.rec.bytes & len_mask(s_rdata.rec.len);
                            emitted_reg <= 1'b1;
                            bidx_reg <= '0;
                            if (s_rdata.rec.kind == KIND_EVENT &&
                                s_rdata.rec.remaining <= 16'd1)
                                valid_reg[idx] <= 1'b0;
                            state_reg <= restore ? S_BRD : S_EMIT;
                        end
                    end
                    else
                    begin
                        unique case (cmd_reg)
                            CMD_ADD:
                                if (sv && s_rdata.rec.ident == id_reg)
                                    hit_reg <= 1'b1;
                            CMD_DEL:
                                if (s_rdata.rec.ident == id_reg && !hit_reg)
                                begin
                                    hit_reg <= 1'b1;
                                    valid_reg[idx] <= 1'b0;
                                end
                            CMD_DELALL:
                                valid_reg[idx] <= 1'b0;
                            CMD_PAUSE, CMD_RESUME:
                                if (s_rdata.rec.ident == id_reg)
                                begin
                                    hit_reg <= 1'b1;
                                    valid_reg[idx] <= (cmd_reg == CMD_RESUME);
                                end
                            CMD_SETD:
                                if (sv && s_rdata.rec.ident == id_reg)
                                    hit_reg <= 1'b1;
                            CMD_GETD:
                                if (sv && s_rdata.rec.ident == id_reg)
                                begin
                                    hit_reg <= 1'b1;
                                    rlen_reg <= s_rdata.rec.len;
                                    rdata_reg <= s_rdata.rec.bytes & len_mask(s_rdata.rec.len);
                                end
                            default: ;
                        endcase
                        if (idx_reg == CW'(SLOTS - 1))
                        begin
                            if (cmd_reg == CMD_ADD && !hit_reg &&
                                !(sv && s_rdata.rec.ident == id_reg))
                            begin
                                idx_reg <= '0;
                                state_reg <= S_ADD2RD;
                            end
                            else
                                state_reg <= S_FIN;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + CW'(1);
                            state_reg <= S_RD;
                        end
                    end
                S_ADD2RD:
                    state_reg <= S_ADD2CHK;
                S_ADD2CHK:
                begin
                    if (!sv && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                        valid_reg[idx] <= 1'b1;
                        if (kind_reg != KIND_EVENT)
                            bpres_reg[idx] <= 1'b1;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= (idx_reg == CW'(SLOTS - 1)) ? S_FIN : S_ADD2RD;
                end
                S_BRD:
                    state_reg <= S_BCHK;
                S_BCHK:
                    if (bpres_reg[bidx_reg[SW-1:0]] && b_rdata.ident == cur_reg.rec.ident)
                    begin
                        cur_reg <= '{rec: b_rdata, sent_at: 32'd0};
                        state_reg <= S_EMIT;
                    end
                    else if (bidx_reg == CW'(SLOTS - 1))
                        state_reg <= S_EMIT;
                    else
                    begin
                        bidx_reg <= bidx_reg + CW'(1);
                        state_reg <= S_BRD;
                    end
                S_EMIT:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= (idx_reg == CW'(SLOTS - 1)) ? S_FIN : S_RD;
                end
                S_FIN:
                    if (out_free || (cmd_reg == CMD_TICK && !emitted_reg))
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign status = os_reg;
    assign is_frame = of_reg;
    assign out_id = oid_reg;
    assign out_dlc = odlc_reg;
    assign out_data = odata_reg;
    assign last = ol_reg;
endmodule

### sim/can_periodic_tx_scheduler_tb.sv
`timescale 1ns / 1ps
module can_periodic_tx_scheduler_tb;
    import cpts_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_frame;
        logic [28:0] out_id;
        logic [3:0]  out_dlc;
        logic [63:0] out_data;
        logic        last;
    } result_t;

    class tx_scoreboard;
        rec_t        slot_rec[SLOTS];
        bit          slot_live[SLOTS];
        logic [31:0] slot_sent[SLOTS];
        bit          has_backup[SLOTS];
        rec_t        backup_rec[SLOTS];
        logic [31:0] now_ms;
        bit          run;
        result_t     pending[$];
        int          errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_rec[i] = '0;
                slot_live[i] = 0;
                slot_sent[i] = '0;
                has_backup[i] = 0;
                backup_rec[i] = '0;
            end
            now_ms = '0;
            run = 0;
            errors = 0;
        endfunction

        function logic [63:0] byte_mask(logic [3:0] len);
            if (len >= 4'd8)
                return '1;
            return (64'h1 << (8 * len)) - 64'h1;
        endfunction

        function void clear_slot(int i);
            slot_rec[i] = '0;
            slot_live[i] = 0;
            slot_sent[i] = '0;
        endfunction

        function void run_tick();
            result_t e;
            int      n;
            if (!run)
                return;
            now_ms = now_ms + 32'd1;
            n = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_live[i] || 32'(now_ms - slot_sent[i]) < 32'(slot_rec[i].period))
                    continue;
                slot_sent[i] = now_ms;
                e = '0;
                e.is_frame = 1'b1;
                e.out_id = slot_rec[i].ident;
                e.out_dlc = slot_rec[i].len;
                e.out_data = slot_rec[i].bytes & byte_mask(slot_rec[i].len);
                pending.push_back(e);
                n++;
                if (slot_rec[i].kind == KIND_EVENT)
                begin
                    if (slot_rec[i].remaining <= 16'd1)
                    begin
                        slot_rec[i].remaining = '0;
                        slot_live[i] = 0;
                    end
                    else
                        slot_rec[i].remaining--;
                end
                else if (slot_rec[i].kind == KIND_OVERRIDE && slot_rec[i].remaining != 0)
                begin
                    slot_rec[i].remaining--;
                    if (slot_rec[i].remaining == 0)
                    begin
                        // first stored snapshot with this id wins
                        for (int j = 0; j < SLOTS; j++)
                        begin
                            if (has_backup[j] && backup_rec[j].ident == slot_rec[i].ident)
                            begin
                                slot_rec[i] = backup_rec[j];
                                slot_live[i] = 1;
                                slot_sent[i] = '0;
                                break;
                            end
                        end
                    end
                end
            end
            if (n > 0)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void note_request(logic [3:0] c, logic [28:0] id, logic [3:0] dlc,
                                   logic [63:0] data, logic [15:0] per,
                                   logic [1:0] kind, logic [15:0] cnt);
            rec_t        r;
            result_t     e;
            bit          hit;
            logic [63:0] m;
            e = '0;
            e.last = 1'b1;
            hit = 0;
            r.ident = id;
            r.len = (dlc > 4'd8) ? 4'd8 : dlc;
            r.bytes = data;
            r.period = per;
            r.kind = kind;
            r.remaining = cnt;
            case (c)
                CMD_TICK:
                begin
                    run_tick();
                    return;
                end
                CMD_ADD:
                begin
                    for (int i = 0; i < SLOTS && !hit; i++)
                        if (slot_live[i] && slot_rec[i].ident == id)
                        begin
                            slot_rec[i] = r;
                            hit = 1;
                        end
                    for (int i = 0; i < SLOTS && !hit; i++)
                        if (!slot_live[i])
                        begin
                            slot_rec[i] = r;
                            slot_live[i] = 1;
                            slot_sent[i] = '0;
                            if (kind != KIND_EVENT)
                            begin
                                backup_rec[i] = r;
                                has_backup[i] = 1;
                            end
                            hit = 1;
                        end
                    if (!hit)
                        e.status = ST_FULL;
                end
                CMD_DEL:
                begin
                    for (int i = 0; i < SLOTS && !hit; i++)
                        if (slot_rec[i].ident == id)
                        begin
                            clear_slot(i);
                            hit = 1;
                        end
                    if (!hit)
                        e.status = ST_NOTFOUND;
                end
                CMD_DELALL:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i])
                            clear_slot(i);
                end
                CMD_PAUSE, CMD_RESUME:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_rec[i].ident == id)
                        begin
                            slot_live[i] = (c == CMD_RESUME);
                            hit = 1;
                        end
                    if (!hit)
                        e.status = ST_NOTFOUND;
                end
                CMD_SETD:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i] && slot_rec[i].ident == id)
                        begin
                            m = byte_mask(slot_rec[i].len);
                            slot_rec[i].bytes = (slot_rec[i].bytes & ~m) | (data & m);
                            hit = 1;
                        end
                    if (!hit)
                        e.status = ST_NOTFOUND;
                end
                CMD_GETD:
                begin
                    // last matching slot supplies the data
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i] && slot_rec[i].ident == id)
                        begin
                            e.out_dlc = slot_rec[i].len;
                            e.out_data = slot_rec[i].bytes & byte_mask(slot_rec[i].len);
                            hit = 1;
                        end
                    if (!hit)
                        e.status = ST_NOTFOUND;
                end
                CMD_START:
                begin
                    now_ms = '0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i])
                            slot_sent[i] = '0;
                    run = 1;
                end
                CMD_STOP:
                    run = 0;
                default:
                    ;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result st=%0d fr=%0d id=%h dlc=%0d data=%h last=%0d",
                             $realtime, got.status, got.is_frame, got.out_id, got.out_dlc,
                             got.out_data, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.is_frame !== want.is_frame ||
                got.out_id !== want.out_id || got.out_dlc !== want.out_dlc ||
                got.out_data !== want.out_data || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t mismatch exp st=%0d fr=%0d id=%h dlc=%0d data=%h last=%0d",
                             $realtime, want.status, want.is_frame, want.out_id,
                             want.out_dlc, want.out_data, want.last);
                    $display("         got st=%0d fr=%0d id=%h dlc=%0d data=%h last=%0d",
                             got.status, got.is_frame, got.out_id, got.out_dlc,
                             got.out_data, got.last);
                end
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  cmd;
    logic [28:0] msg_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [15:0] period_ms;
    logic [1:0]  send_type;
    logic [15:0] repeat_count;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic        is_frame;
    logic [28:0] out_id;
    logic [3:0]  out_dlc;
    logic [63:0] out_data;
    logic        last;

    tx_scoreboard sb;
    bit           quiet;
    int           stall_cycles;
    int           rx_hold;
    logic [28:0]  id_pool[6];

    can_periodic_tx_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .msg_id(msg_id), .dlc(dlc), .payload(payload),
        .period_ms(period_ms), .send_type(send_type), .repeat_count(repeat_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .is_frame(is_frame), .out_id(out_id),
        .out_dlc(out_dlc), .out_data(out_data), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result check and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result({status, is_frame, out_id, out_dlc, out_data, last});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        rx_hold = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                rx_hold = $urandom_range(1, 16) - 1;
            end
            else
                out_ready = 1'b1;
        end
    end

    task automatic send_req(input logic [3:0] c, input logic [28:0] id,
                            input logic [3:0] d, input logic [63:0] p,
                            input logic [15:0] per, input logic [1:0] k,
                            input logic [15:0] n);
        @(negedge clk);
        cmd = c;
        msg_id = id;
        dlc = d;
        payload = p;
        period_ms = per;
        send_type = k;
        repeat_count = n;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(c, id, d, p, per, k, n);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clk);
        end
    endtask

    function automatic logic [28:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, 5)];
        return 29'($urandom);
    endfunction

    task automatic random_req();
        int          r;
        logic [3:0]  c;
        logic [15:0] per;
        logic [15:0] n;
        r = $urandom_range(0, 99);
        if (r < 35)
            c = CMD_TICK;
        else if (r < 58)
            c = CMD_ADD;
        else if (r < 63)
            c = CMD_DEL;
        else if (r < 66)
            c = CMD_DELALL;
        else if (r < 71)
            c = CMD_PAUSE;
        else if (r < 76)
            c = CMD_RESUME;
        else if (r < 83)
            c = CMD_SETD;
        else if (r < 91)
            c = CMD_GETD;
        else if (r < 96)
            c = CMD_START;
        else
            c = CMD_STOP;
        per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        n = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        send_req(c, pick_id(), 4'($urandom_range(0, 8)), {$urandom, $urandom},
                 per, 2'($urandom_range(0, 2)), n);
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        stall_cycles = 0;
        id_pool = '{29'h0, 29'h1FFFFFFF, 29'h1, 29'h123, 29'h0ABCDEF, 29'h15555555};
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        msg_id = '0;
        dlc = '0;
        payload = '0;
        period_ms = '0;
        send_type = '0;
        repeat_count = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill the table, overflow it, then exercise each command
        send_req(CMD_ADD, 29'h1FFFFFFF, 4'd8, '1, 16'd0, KIND_OVERRIDE, 16'd2);
        send_req(CMD_ADD, 29'h0, 4'd0, '0, 16'hFFFF, KIND_PERIODIC, 16'hFFFF);
        send_req(CMD_ADD, 29'h1FFFFFFF, 4'd4, 64'h0123456789ABCDEF, 16'd0,
                 KIND_OVERRIDE, 16'd2);
        for (int i = 0; i < 14; i++)
            send_req(CMD_ADD, 29'h100 + 29'(i), 4'(i % 9), {$urandom, $urandom},
                     16'(i % 3), 2'(i % 3), 16'(i % 4));
        send_req(CMD_ADD, 29'h0ABCDEF, 4'd8, '1, 16'd1, KIND_EVENT, 16'd1);
        send_req(CMD_START, '0, '0, '0, '0, '0, '0);
        repeat (3) send_req(CMD_TICK, '0, '0, '0, '0, '0, '0);
        send_req(CMD_SETD, 29'h1FFFFFFF, '0, 64'hA5A5A5A5A5A5A5A5, '0, '0, '0);
        send_req(CMD_GETD, 29'h1FFFFFFF, '0, '0, '0, '0, '0);
        send_req(CMD_PAUSE, 29'h101, '0, '0, '0, '0, '0);
        send_req(CMD_RESUME, 29'h101, '0, '0, '0, '0, '0);
        send_req(CMD_DEL, 29'h0ABCDEF, '0, '0, '0, '0, '0);
        send_req(CMD_GETD, 29'h0ABCDEF, '0, '0, '0, '0, '0);
        send_req(CMD_STOP, '0, '0, '0, '0, '0, '0);
        send_req(CMD_TICK, '0, '0, '0, '0, '0, '0);
        send_req(CMD_DELALL, '0, '0, '0, '0, '0, '0);
        send_req(CMD_START, '0, '0, '0, '0, '0, '0);

        for (int i = 0; i < 130; i++)
        begin
            if (i == 65)
            begin
                // hold off until the block has drained
                @(negedge clk);
                in_valid = 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            if (i == 105)
                quiet = 1;
            random_req();
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### can_periodic_tx_scheduler.f
rtl/cpts_pkg.sv
rtl/cpts_ram.sv
rtl/can_periodic_tx_scheduler.sv
sim/can_periodic_tx_scheduler_tb.sv
